// ===== rtl/lsf2lpc_pkg.sv =====
package lsf2lpc_pkg;

  // Fixed field and register widths.
  localparam int FREQ_W  = 16;
  localparam int NYQ_W   = 16;
  localparam int ORDER_W = 5;
  localparam int LPC_W   = 16;
  localparam int CFG_W   = 16;

  // Polynomial coefficients are signed Q24 in 40 bits.
  localparam int COEF_W = 40;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 40'sd16777216;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 40'sh7F_FFFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd10;
  localparam logic [NYQ_W-1:0]   NYQ_RESET   = 16'd8000;

  // Round(pi * 2^30).
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Cosine series: seven terms, Q30 accumulator.
  localparam int TERM_W       = 32;
  localparam int ACC_W        = 36;
  localparam int MAG_W        = 26;
  localparam int TAYLOR_TERMS = 7;

  // Iterative divider: four quotient bits per cycle.
  localparam int DIV_NUM_W  = 36;
  localparam int DIV_DEN_W  = 17;
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITER   = DIV_NUM_W / DIV_STEP;
  localparam int DIV_CNT_W  = 4;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_FILTER_ORDER = 1'b0,
    REG_NYQUIST_HZ   = 1'b1
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_IDX_START,
    S_IDX_WAIT,
    S_X_MUL,
    S_X_TAKE,
    S_XX_MUL,
    S_X2_TAKE,
    S_T_MUL,
    S_T_START,
    S_T_WAIT,
    S_C_TAKE,
    S_Q_RD,
    S_Q_MH,
    S_Q_WR,
    S_F_RD,
    S_F_CALC
  } ctrl_state_t;

  // Datapath operations, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_IDX_START,
    OP_IDX_TAKE,
    OP_X_MUL,
    OP_X_TAKE,
    OP_XX_MUL,
    OP_X2_TAKE,
    OP_T_MUL,
    OP_T_START,
    OP_T_TAKE,
    OP_C_TAKE,
    OP_Q_RD,
    OP_Q_MH,
    OP_Q_WR,
    OP_F_RD,
    OP_F_CALC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic term_last;
    logic j_last;
    logic frame_done;
    logic out_free;
    logic fin_j0;
    logic fin_last;
  } dp_sts_t;

  // Denominator of the m-th series term: (2m-1)(2m).
  function automatic logic [7:0] taylor_den(input logic [2:0] m);
    int mi;
    mi = int'(m);
    return 8'((2 * mi - 1) * (2 * mi));
  endfunction

  // Saturate to +-(2^39-1).
  function automatic logic signed [COEF_W-1:0] sat40(input logic signed [43:0] v);
    logic signed [43:0] lim;
    lim = 44'(COEF_MAX);
    if (v > lim) begin
      return COEF_MAX;
    end else if (v < -lim) begin
      return -COEF_MAX;
    end
    return COEF_W'(v);
  endfunction

  // Shift right by 13 with rounding away from zero, then saturate to 16 bits.
  function automatic logic signed [LPC_W-1:0] round_q12(input logic signed [40:0] v);
    logic [40:0] mag;
    logic [40:0] r;
    mag = v[40] ? 41'(-v) : 41'(v);
    r   = (mag + 41'd4096) >> 13;
    if (!v[40] && r > 41'd32767) begin
      return 16'sd32767;
    end else if (v[40] && r > 41'd32768) begin
      return -16'sd32768;
    end
    return v[40] ? LPC_W'(-r) : LPC_W'(r);
  endfunction

endpackage

// ===== rtl/line_spectral_freqs_to_lpc_core.sv =====
// Line spectral frequency to LPC converter.
// Input channel (freq_valid / freq_stall / line_freq_hz) takes one frequency
// in Hz per item; filter_order items, clamped to 1..MAX_ORDER, make one frame.
// Output channel (coeff_valid / coeff_stall) gives one item per LPC coefficient,
// index order first and index 1 last, with last_coeff set on the final one.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, as the block does not enforce this:
// index 0 is filter_order, index 1 is nyquist_hz. The cosine series runs
// seven terms through one shared 32x32 multiplier and a divider that
// resolves four quotient bits per cycle, and the polynomial update visits
// each coefficient with a read, a split multiply and a write on stores
// with one write and one read port. The frame's last item also sends the
// coefficients. Input stall is high whenever an item is in work.
// A stalled output holds its item and pauses the frame-end sweep.
// Reset restores filter_order 10, nyquist_hz 8000 and an empty frame; the
// block is ready on the cycle after reset is released.
module line_spectral_freqs_to_lpc_core #(
  parameter int MAX_ORDER      = 16,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [lsf2lpc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                  freq_valid,
  output logic                                  freq_stall,
  input  logic [lsf2lpc_pkg::FREQ_W-1:0]        line_freq_hz,
  output logic                                  coeff_valid,
  input  logic                                  coeff_stall,
  output logic signed [lsf2lpc_pkg::LPC_W-1:0]  lpc_coeff,
  output logic [lsf2lpc_pkg::ORDER_W-1:0]       coeff_index,
  output logic                                  last_coeff
);

  lsf2lpc_pkg::dp_cmd_t cmd;
  lsf2lpc_pkg::dp_sts_t sts;

  lsf2lpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .freq_valid (freq_valid),
    .freq_stall (freq_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  lsf2lpc_dp #(
    .MAX_ORDER      (MAX_ORDER),
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .line_freq_hz (line_freq_hz),
    .coeff_valid  (coeff_valid),
    .coeff_stall  (coeff_stall),
    .lpc_coeff    (lpc_coeff),
    .coeff_index  (coeff_index),
    .last_coeff   (last_coeff)
  );

endmodule

// ===== rtl/lsf2lpc_ram.sv =====
module lsf2lpc_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lsf2lpc_div.sv =====
module lsf2lpc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [lsf2lpc_pkg::DIV_NUM_W-1:0]   num,
  input  logic [lsf2lpc_pkg::DIV_DEN_W-1:0]   den,
  output logic                                done,
  output logic [lsf2lpc_pkg::DIV_NUM_W-1:0]   quot
);

  localparam int NW = lsf2lpc_pkg::DIV_NUM_W;
  localparam int DW = lsf2lpc_pkg::DIV_DEN_W;

  logic                                busy;
  logic [lsf2lpc_pkg::DIV_CNT_W-1:0]   cnt;
  logic [DW-1:0]                       rem;
  logic [DW-1:0]                       rem_next;
  logic [DW-1:0]                       den_q;
  logic [NW-1:0]                       shreg;
  logic [NW-1:0]                       shreg_next;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [DW:0] t;
    logic        qb;
    rem_next   = rem;
    shreg_next = shreg;
    for (int b = 0; b < lsf2lpc_pkg::DIV_STEP; b++) begin
      t = {rem_next, shreg_next[NW-1]};
      qb = (t >= {1'b0, den_q});
      if (qb) begin
        rem_next = DW'(t - {1'b0, den_q});
      end else begin
        rem_next = t[DW-1:0];
      end
      shreg_next = {shreg_next[NW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        shreg <= num;
        den_q <= den;
      end else if (busy) begin
        rem   <= rem_next;
        shreg <= shreg_next;
        cnt   <= cnt + 1'b1;
        if (cnt == lsf2lpc_pkg::DIV_CNT_W'(lsf2lpc_pkg::DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = shreg;

endmodule

// ===== rtl/lsf2lpc_dp.sv =====
module lsf2lpc_dp #(
  parameter int MAX_ORDER      = 16,
  parameter int COS_TABLE_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lsf2lpc_pkg::dp_cmd_t                   cmd,
  output lsf2lpc_pkg::dp_sts_t                   sts,
  input  logic                                   cfg_we,
  input  logic [0:0]                             cfg_index,
  input  logic [lsf2lpc_pkg::CFG_W-1:0]          cfg_data,
  input  logic [lsf2lpc_pkg::FREQ_W-1:0]         line_freq_hz,
  output logic                                   coeff_valid,
  input  logic                                   coeff_stall,
  output logic signed [lsf2lpc_pkg::LPC_W-1:0]   lpc_coeff,
  output logic [lsf2lpc_pkg::ORDER_W-1:0]        coeff_index,
  output logic                                   last_coeff
);

  localparam int POLY_LEN = MAX_ORDER + 2;
  localparam int AW       = $clog2(POLY_LEN);
  localparam int IW       = COS_TABLE_BITS + 1;
  localparam int CW       = lsf2lpc_pkg::COEF_W;
  localparam int OW       = lsf2lpc_pkg::ORDER_W;
  localparam int NW       = lsf2lpc_pkg::DIV_NUM_W;
  localparam int AC       = lsf2lpc_pkg::ACC_W;
  localparam logic [IW-1:0] TABLE_TOP  = IW'(1) << COS_TABLE_BITS;
  localparam logic [IW-1:0] TABLE_HALF = IW'(1) << (COS_TABLE_BITS - 1);

  lsf2lpc_pkg::dp_op_t op;
  assign op = cmd.op;

  // Configuration and frame bookkeeping.
  logic [OW-1:0]                   order_cfg;
  logic [lsf2lpc_pkg::NYQ_W-1:0]   nyq_cfg;
  logic [OW-1:0]                   items_seen;
  logic [OW-1:0]                   k;
  logic [OW-1:0]                   n_eff;
  logic [lsf2lpc_pkg::FREQ_W-1:0]  f_q;
  logic [lsf2lpc_pkg::NYQ_W-1:0]   nyq_q;

  // Cosine evaluation.
  logic [IW-1:0]                   kk;
  logic                            upper;
  logic [31:0]                     x;
  logic [31:0]                     x2;
  logic [lsf2lpc_pkg::TERM_W-1:0]  term;
  logic signed [AC-1:0]            acc;
  logic [2:0]                      m;
  logic [lsf2lpc_pkg::MAG_W-1:0]   mc;
  logic                            c_neg;

  // Shared multiplier.
  logic [31:0]                     mul_a;
  logic [31:0]                     mul_b;
  logic [63:0]                     mul_p;
  logic [63:0]                     mreg;
  logic [45:0]                     pplo;

  // Polynomial sweep.
  logic [AW-1:0]                   j;
  logic signed [CW-1:0]            sold1, sold2, dold1, dold2;
  logic [POLY_LEN-1:0]             sval, dval;
  logic                            rv_s, rv_d, rd_j0;
  logic [CW-1:0]                   ram_s_q, ram_d_q;
  logic signed [CW-1:0]            rd_s, rd_d;

  // Divider hookup.
  logic                            div_start;
  logic [NW-1:0]                   div_num;
  logic [lsf2lpc_pkg::DIV_DEN_W-1:0] div_den;
  logic                            div_done;
  logic [NW-1:0]                   div_q;

  // Effective configuration at the moment an item is taken.
  logic [lsf2lpc_pkg::NYQ_W-1:0]   nyq_eff;
  logic [OW-1:0]                   n_now;
  logic [lsf2lpc_pkg::FREQ_W-1:0]  f_clamp;
  assign nyq_eff = (nyq_cfg == '0) ? lsf2lpc_pkg::NYQ_W'(1) : nyq_cfg;
  assign f_clamp = (line_freq_hz > nyq_eff) ? nyq_eff : line_freq_hz;
  always_comb begin
    if (order_cfg == '0) begin
      n_now = OW'(1);
    end else if ({1'b0, order_cfg} > (OW + 1)'(MAX_ORDER)) begin
      n_now = OW'(MAX_ORDER);
    end else begin
      n_now = order_cfg;
    end
  end

  // Divider operands: table index or one series term.
  always_comb begin
    logic [64:0] tsum;
    tsum      = {1'b0, mreg} + (65'(lsf2lpc_pkg::taylor_den(m)) << 29);
    div_start = (op == lsf2lpc_pkg::OP_IDX_START) || (op == lsf2lpc_pkg::OP_T_START);
    if (op == lsf2lpc_pkg::OP_IDX_START) begin
      div_num = (NW'(f_q) << (COS_TABLE_BITS + 1)) + NW'(nyq_q);
      div_den = {nyq_q, 1'b0};
    end else begin
      div_num = NW'(tsum >> 30);
      div_den = lsf2lpc_pkg::DIV_DEN_W'(lsf2lpc_pkg::taylor_den(m));
    end
  end

  lsf2lpc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Old coefficient of the polynomial being updated.
  logic                   sel;
  logic signed [CW-1:0]   old1s, old2s;
  logic [CW-1:0]          o1mag;
  assign sel   = k[0];
  assign old1s = sel ? sold1 : dold1;
  assign old2s = sel ? sold2 : dold2;
  assign o1mag = old1s[CW-1] ? CW'(-old1s) : CW'(old1s);

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      lsf2lpc_pkg::OP_X_MUL: begin
        mul_a = 32'(kk);
        mul_b = lsf2lpc_pkg::PI_Q30;
      end
      lsf2lpc_pkg::OP_XX_MUL: begin
        mul_a = x;
        mul_b = x;
      end
      lsf2lpc_pkg::OP_T_MUL: begin
        mul_a = term;
        mul_b = x2;
      end
      lsf2lpc_pkg::OP_Q_RD: begin
        mul_a = 32'(mc);
        mul_b = 32'(o1mag[19:0]);
      end
      lsf2lpc_pkg::OP_Q_MH: begin
        mul_a = 32'(mc);
        mul_b = 32'(o1mag[38:20]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Final coefficient c = -2cos(angle) as magnitude and sign.
  logic signed [AC-1:0]  nv;
  logic [AC-1:0]         nmag;
  logic [AC-1:0]         cr;
  logic [lsf2lpc_pkg::MAG_W-1:0] mc_next;
  assign nv      = upper ? acc : -acc;
  assign nmag    = nv[AC-1] ? AC'(-nv) : AC'(nv);
  assign cr      = (nmag + AC'(16)) >> 5;
  assign mc_next = (cr > (AC'(1) << 25)) ? (lsf2lpc_pkg::MAG_W'(1) << 25)
                                         : lsf2lpc_pkg::MAG_W'(cr);

  // Entries not yet written read as the reset value.
  assign rd_s = rv_s ? $signed(ram_s_q) : (rd_j0 ? lsf2lpc_pkg::COEF_ONE : '0);
  assign rd_d = rv_d ? $signed(ram_d_q) : (rd_j0 ? lsf2lpc_pkg::COEF_ONE : '0);

  // Quadratic update: p[j] + c*p[j-1] + p[j-2].
  logic [64:0]           prod;
  logic [40:0]           prq;
  logic signed [43:0]    pval;
  logic signed [43:0]    qsum;
  logic signed [CW-1:0]  qnew;
  logic signed [CW-1:0]  rds;
  assign rds  = sel ? rd_s : rd_d;
  assign prod = 65'(pplo) + (65'(mreg) << 20);
  assign prq  = 41'((prod + 65'(1 << 23)) >> 24);
  assign pval = (c_neg ^ old1s[CW-1]) ? -$signed({3'b000, prq}) : $signed({3'b000, prq});
  assign qsum = 44'(rds) + pval + 44'(old2s);
  assign qnew = lsf2lpc_pkg::sat40(qsum);

  // Frame end: linear factors and the output coefficient.
  logic signed [CW-1:0]  snew, dnew;
  logic signed [40:0]    tot;
  always_comb begin
    if (!k[0]) begin
      snew = lsf2lpc_pkg::sat40(44'(sold1) + 44'(rd_s));
      dnew = lsf2lpc_pkg::sat40(44'(dold1) - 44'(rd_d));
    end else begin
      snew = rd_s;
      dnew = lsf2lpc_pkg::sat40(44'(dold2) - 44'(rd_d));
    end
  end
  assign tot = 41'(snew) + 41'(dnew);

  // Polynomial stores.
  logic rd_en, wr_s, wr_d;
  assign rd_en = (op == lsf2lpc_pkg::OP_Q_RD) || (op == lsf2lpc_pkg::OP_F_RD);
  assign wr_s  = (op == lsf2lpc_pkg::OP_Q_WR) && sel;
  assign wr_d  = (op == lsf2lpc_pkg::OP_Q_WR) && !sel;

  lsf2lpc_ram #(.WIDTH(CW), .DEPTH(POLY_LEN)) u_sum_ram (
    .clk   (clk),
    .we    (wr_s),
    .waddr (j),
    .wdata (qnew),
    .re    (rd_en),
    .raddr (j),
    .rdata (ram_s_q)
  );

  lsf2lpc_ram #(.WIDTH(CW), .DEPTH(POLY_LEN)) u_diff_ram (
    .clk   (clk),
    .we    (wr_d),
    .waddr (j),
    .wdata (qnew),
    .re    (rd_en),
    .raddr (j),
    .rdata (ram_d_q)
  );

  // Status toward the controller.
  logic out_free;
  assign out_free        = !coeff_valid || !coeff_stall;
  assign sts.div_done    = div_done;
  assign sts.term_last   = (m == 3'(lsf2lpc_pkg::TAYLOR_TERMS));
  assign sts.j_last      = (j == AW'(POLY_LEN - 1));
  assign sts.frame_done  = (k >= n_eff);
  assign sts.out_free    = out_free;
  assign sts.fin_j0      = (j == '0);
  assign sts.fin_last    = (32'(j) == 32'(k));

  // Control registers: configuration, frame count, valid bits, output flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      order_cfg   <= lsf2lpc_pkg::ORDER_RESET;
      nyq_cfg     <= lsf2lpc_pkg::NYQ_RESET;
      items_seen  <= '0;
      sval        <= '0;
      dval        <= '0;
      coeff_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (lsf2lpc_pkg::cfg_reg_t'(cfg_index))
          lsf2lpc_pkg::REG_FILTER_ORDER: order_cfg <= cfg_data[OW-1:0];
          lsf2lpc_pkg::REG_NYQUIST_HZ:   nyq_cfg   <= cfg_data;
          default: ;
        endcase
      end
      if (coeff_valid && !coeff_stall) begin
        coeff_valid <= 1'b0;
      end
      case (op)
        lsf2lpc_pkg::OP_ACCEPT: begin
          items_seen <= items_seen + 1'b1;
        end
        lsf2lpc_pkg::OP_Q_WR: begin
          if (sel) begin
            sval[j] <= 1'b1;
          end else begin
            dval[j] <= 1'b1;
          end
        end
        lsf2lpc_pkg::OP_F_CALC: begin
          if (j != '0) begin
            coeff_valid <= 1'b1;
          end
          if (32'(j) == 32'(k)) begin
            sval       <= '0;
            dval       <= '0;
            items_seen <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      lsf2lpc_pkg::OP_ACCEPT: begin
        f_q   <= f_clamp;
        nyq_q <= nyq_eff;
        n_eff <= n_now;
        k     <= items_seen + 1'b1;
      end
      lsf2lpc_pkg::OP_IDX_TAKE: begin
        logic [IW-1:0] idx;
        idx   = (div_q > NW'(TABLE_TOP)) ? TABLE_TOP : IW'(div_q);
        upper <= (idx > TABLE_HALF);
        kk    <= (idx > TABLE_HALF) ? IW'(TABLE_TOP - idx) : idx;
      end
      lsf2lpc_pkg::OP_X_TAKE: begin
        x <= 32'((mreg + 64'(TABLE_HALF)) >> COS_TABLE_BITS);
      end
      lsf2lpc_pkg::OP_X2_TAKE: begin
        x2   <= 32'((mreg + (64'(1) << 29)) >> 30);
        term <= 32'(1) << 30;
        acc  <= AC'(1) << 30;
        m    <= 3'd1;
      end
      lsf2lpc_pkg::OP_T_TAKE: begin
        term <= lsf2lpc_pkg::TERM_W'(div_q);
        acc  <= m[0] ? acc - $signed(AC'(div_q[31:0])) : acc + $signed(AC'(div_q[31:0]));
        m    <= m + 1'b1;
      end
      lsf2lpc_pkg::OP_C_TAKE: begin
        mc    <= mc_next;
        c_neg <= nv[AC-1];
        j     <= '0;
        sold1 <= '0;
        sold2 <= '0;
        dold1 <= '0;
        dold2 <= '0;
      end
      lsf2lpc_pkg::OP_Q_RD, lsf2lpc_pkg::OP_F_RD: begin
        rv_s  <= sval[j];
        rv_d  <= dval[j];
        rd_j0 <= (j == '0);
      end
      lsf2lpc_pkg::OP_Q_MH: begin
        pplo <= mreg[45:0];
      end
      lsf2lpc_pkg::OP_Q_WR: begin
        if (j == AW'(POLY_LEN - 1)) begin
          j     <= '0;
          sold1 <= '0;
          sold2 <= '0;
          dold1 <= '0;
          dold2 <= '0;
        end else begin
          j <= j + 1'b1;
          if (sel) begin
            sold2 <= sold1;
            sold1 <= rd_s;
          end else begin
            dold2 <= dold1;
            dold1 <= rd_d;
          end
        end
      end
      lsf2lpc_pkg::OP_F_CALC: begin
        j     <= j + 1'b1;
        sold2 <= sold1;
        sold1 <= rd_s;
        dold2 <= dold1;
        dold1 <= rd_d;
        if (j != '0) begin
          lpc_coeff   <= lsf2lpc_pkg::round_q12(tot);
          coeff_index <= OW'(k + 1'b1 - OW'(j));
          last_coeff  <= (32'(j) == 32'(k));
        end
      end
      default: ;
    endcase
    case (op)
      lsf2lpc_pkg::OP_X_MUL, lsf2lpc_pkg::OP_XX_MUL, lsf2lpc_pkg::OP_T_MUL,
      lsf2lpc_pkg::OP_Q_RD, lsf2lpc_pkg::OP_Q_MH: begin
        mreg <= mul_p;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/lsf2lpc_ctrl.sv =====
module lsf2lpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  freq_valid,
  output logic                  freq_stall,
  input  lsf2lpc_pkg::dp_sts_t  sts,
  output lsf2lpc_pkg::dp_cmd_t  cmd
);

  lsf2lpc_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsf2lpc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lsf2lpc_pkg::S_IDLE:      if (freq_valid) state_next = lsf2lpc_pkg::S_IDX_START;
      lsf2lpc_pkg::S_IDX_START: state_next = lsf2lpc_pkg::S_IDX_WAIT;
      lsf2lpc_pkg::S_IDX_WAIT:  if (sts.div_done) state_next = lsf2lpc_pkg::S_X_MUL;
      lsf2lpc_pkg::S_X_MUL:     state_next = lsf2lpc_pkg::S_X_TAKE;
      lsf2lpc_pkg::S_X_TAKE:    state_next = lsf2lpc_pkg::S_XX_MUL;
      lsf2lpc_pkg::S_XX_MUL:    state_next = lsf2lpc_pkg::S_X2_TAKE;
      lsf2lpc_pkg::S_X2_TAKE:   state_next = lsf2lpc_pkg::S_T_MUL;
      lsf2lpc_pkg::S_T_MUL:     state_next = lsf2lpc_pkg::S_T_START;
      lsf2lpc_pkg::S_T_START:   state_next = lsf2lpc_pkg::S_T_WAIT;
      lsf2lpc_pkg::S_T_WAIT: begin
        if (sts.div_done) begin
          state_next = sts.term_last ? lsf2lpc_pkg::S_C_TAKE : lsf2lpc_pkg::S_T_MUL;
        end
      end
      lsf2lpc_pkg::S_C_TAKE:    state_next = lsf2lpc_pkg::S_Q_RD;
      lsf2lpc_pkg::S_Q_RD:      state_next = lsf2lpc_pkg::S_Q_MH;
      lsf2lpc_pkg::S_Q_MH:      state_next = lsf2lpc_pkg::S_Q_WR;
      lsf2lpc_pkg::S_Q_WR: begin
        if (!sts.j_last) begin
          state_next = lsf2lpc_pkg::S_Q_RD;
        end else if (sts.frame_done) begin
          state_next = lsf2lpc_pkg::S_F_RD;
        end else begin
          state_next = lsf2lpc_pkg::S_IDLE;
        end
      end
      lsf2lpc_pkg::S_F_RD:      state_next = lsf2lpc_pkg::S_F_CALC;
      lsf2lpc_pkg::S_F_CALC: begin
        if (sts.fin_j0 || sts.out_free) begin
          state_next = sts.fin_last ? lsf2lpc_pkg::S_IDLE : lsf2lpc_pkg::S_F_RD;
        end
      end
      default:                  state_next = lsf2lpc_pkg::S_IDLE;
    endcase
  end

  // Commands toward the datapath.
  always_comb begin
    cmd.op     = lsf2lpc_pkg::OP_NONE;
    freq_stall = 1'b1;
    case (state)
      lsf2lpc_pkg::S_IDLE: begin
        freq_stall = 1'b0;
        if (freq_valid) cmd.op = lsf2lpc_pkg::OP_ACCEPT;
      end
      lsf2lpc_pkg::S_IDX_START: cmd.op = lsf2lpc_pkg::OP_IDX_START;
      lsf2lpc_pkg::S_IDX_WAIT:  if (sts.div_done) cmd.op = lsf2lpc_pkg::OP_IDX_TAKE;
      lsf2lpc_pkg::S_X_MUL:     cmd.op = lsf2lpc_pkg::OP_X_MUL;
      lsf2lpc_pkg::S_X_TAKE:    cmd.op = lsf2lpc_pkg::OP_X_TAKE;
      lsf2lpc_pkg::S_XX_MUL:    cmd.op = lsf2lpc_pkg::OP_XX_MUL;
      lsf2lpc_pkg::S_X2_TAKE:   cmd.op = lsf2lpc_pkg::OP_X2_TAKE;
      lsf2lpc_pkg::S_T_MUL:     cmd.op = lsf2lpc_pkg::OP_T_MUL;
      lsf2lpc_pkg::S_T_START:   cmd.op = lsf2lpc_pkg::OP_T_START;
      lsf2lpc_pkg::S_T_WAIT:    if (sts.div_done) cmd.op = lsf2lpc_pkg::OP_T_TAKE;
      lsf2lpc_pkg::S_C_TAKE:    cmd.op = lsf2lpc_pkg::OP_C_TAKE;
      lsf2lpc_pkg::S_Q_RD:      cmd.op = lsf2lpc_pkg::OP_Q_RD;
      lsf2lpc_pkg::S_Q_MH:      cmd.op = lsf2lpc_pkg::OP_Q_MH;
      lsf2lpc_pkg::S_Q_WR:      cmd.op = lsf2lpc_pkg::OP_Q_WR;
      lsf2lpc_pkg::S_F_RD:      cmd.op = lsf2lpc_pkg::OP_F_RD;
      lsf2lpc_pkg::S_F_CALC: begin
        if (sts.fin_j0 || sts.out_free) cmd.op = lsf2lpc_pkg::OP_F_CALC;
      end
      default:                  cmd.op = lsf2lpc_pkg::OP_NONE;
    endcase
  end

endmodule
